// ----- sv/plist_pkg.sv -----
// package for the positional list engine: command and status codes,
// stream field widths and beat layout constants
// no dependencies
`default_nettype none

package plist_pkg;

    // input beat fields
    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;

    // result beat fields
    localparam int FOUND_W  = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    // packed beat widths, rounded up to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // bit offsets inside the input beat
    localparam int S_CMD_LSB = 0;
    localparam int S_POS_LSB = S_CMD_LSB + CMD_W;
    localparam int S_VAL_LSB = S_POS_LSB + POS_W;

    // bit offsets inside the result beat
    localparam int M_DATA_LSB   = 0;
    localparam int M_FOUND_LSB  = M_DATA_LSB + VAL_W;
    localparam int M_STATUS_LSB = M_FOUND_LSB + FOUND_W;
    localparam int M_LEN_LSB    = M_STATUS_LSB + STATUS_W;
    localparam int M_EMPTY_LSB  = M_LEN_LSB + LEN_W;
    localparam int M_USED_W     = M_EMPTY_LSB + 1;

    // found position reported when no entry matches
    localparam logic [FOUND_W-1:0] NOT_FOUND = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- sv/positional_list_engine_unit.sv -----
// positional list engine top level: command sequencer over one entry ram
// depends on plist_pkg and plist_ram
`default_nettype none

// channel   dir  handshake          payload
// s_        in   s_tvalid/s_tready  s_tdata: command, position, value
// m_        out  m_tvalid/m_tready  m_tdata: data_out, found_position, status,
//                                   length, is_empty
//
// one command at a time; s_tready is high only while the sequencer is idle.
// insert and delete walk the entries above the position and find walks the list from
// the start to the first match, one entry a cycle; read waits on the registered ram read.
// errors go straight to the result. a result waits in the output register while the
// next command is taken; a stalled m_ side holds only the finishing command.
// synchronous active-low reset empties the list; entries need no clearing.

module positional_list_engine_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // command [1:0], position [8:2], value [40:9], zero fill above
    input  wire logic [plist_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // data_out [31:0], found_position [38:32], status [40:39],
    // length [47:41], is_empty [48], zero fill above
    output logic      [plist_pkg::M_TDATA_W-1:0] m_tdata
);

    import plist_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SCAN,
        S_RD_WAIT,
        S_FIND_SCAN,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [VAL_W-1:0]      val_reg, val_next;
    logic [CW-1:0]         cur_reg, cur_next;
    logic [CW-1:0]         prev_reg, prev_next;
    logic                  pend_reg, pend_next;
    logic [VAL_W-1:0]      data_reg, data_next;
    logic [FOUND_W-1:0]    found_reg, found_next;
    status_t               status_reg, status_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    // ram port signals
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [VAL_W-1:0]      ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [VAL_W-1:0]      ram_rdata;

    // input beat fields
    cmd_t                  in_cmd;
    logic [POS_W-1:0]      in_pos;
    logic [VAL_W-1:0]      in_val;
    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         cnt_x;
    logic [CW-1:0]         prev_dec;
    logic                  accept;

    assign in_cmd   = cmd_t'(s_tdata[S_CMD_LSB +: CMD_W]);
    assign in_pos   = s_tdata[S_POS_LSB +: POS_W];
    assign in_val   = s_tdata[S_VAL_LSB +: VAL_W];
    assign pos_x    = XW'(in_pos);
    assign cnt_x    = XW'(count_reg);
    assign prev_dec = prev_reg - CW'(1);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    plist_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // command sequencer
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        pend_next     = pend_reg;
        data_next     = data_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        ram_we    = 1'b0;
        ram_waddr = prev_reg[AW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = cur_reg[AW-1:0];

        // result beat taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                ram_raddr = AW'(in_pos);
                if (accept) begin
                    pos_next    = CW'(in_pos);
                    val_next    = in_val;
                    data_next   = '0;
                    found_next  = NOT_FOUND;
                    status_next = ST_OK;
                    pend_next   = 1'b0;
                    case (in_cmd)
                        CMD_INSERT: begin
                            if (pos_x > cnt_x) begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end else if (count_reg == CW'(CAPACITY)) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                cur_next   = count_reg;
                                state_next = S_INS_SHIFT;
                            end
                        end
                        CMD_DELETE: begin
                            if (pos_x >= cnt_x) begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end else begin
                                cur_next   = CW'(in_pos);
                                state_next = S_DEL_SCAN;
                            end
                        end
                        CMD_READ: begin
                            if (pos_x >= cnt_x) begin
                                status_next = ST_BADPOS;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        CMD_FIND: begin
                            cur_next   = '0;
                            state_next = S_FIND_SCAN;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // move entries up one place, top first, read one and write one a cycle
            S_INS_SHIFT: begin
                if (pend_reg) begin
                    ram_we = 1'b1;
                end
                if (cur_reg > pos_reg) begin
                    ram_raddr = cur_reg[AW-1:0] - AW'(1);
                    prev_next = cur_reg;
                    cur_next  = cur_reg - CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_INS_PUT;
                end
            end

            S_INS_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[AW-1:0];
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            // read from the position upward; the first beat is the deleted
            // value, the rest drop one place down
            S_DEL_SCAN: begin
                if (pend_reg) begin
                    if (prev_reg == pos_reg) begin
                        data_next = ram_rdata;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = prev_dec[AW-1:0];
                    end
                end
                if (cur_reg < count_reg) begin
                    prev_next = cur_reg;
                    cur_next  = cur_reg + CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
            end

            S_RD_WAIT: begin
                data_next  = ram_rdata;
                state_next = S_DONE;
            end

            // compare each stored entry against the search value in turn
            S_FIND_SCAN: begin
                if (pend_reg && (ram_rdata == val_reg)) begin
                    found_next = FOUND_W'(prev_reg);
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end else if (cur_reg < count_reg) begin
                    prev_next = cur_reg;
                    cur_next  = cur_reg + CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = S_DONE;
                end
            end

            // load the result beat once the output register is free
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[M_DATA_LSB +: VAL_W]      = data_reg;
                    m_tdata_next[M_FOUND_LSB +: FOUND_W]   = found_reg;
                    m_tdata_next[M_STATUS_LSB +: STATUS_W] = status_reg;
                    m_tdata_next[M_LEN_LSB +: LEN_W]       = LEN_W'(count_reg);
                    m_tdata_next[M_EMPTY_LSB]              = (count_reg == '0);
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        cur_reg     <= cur_next;
        prev_reg    <= prev_next;
        data_reg    <= data_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ----- sv/plist_ram.sv -----
// generic single-clock ram: one write port, one read port, registered read
// no dependencies
`default_nettype none

module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for positional_list_engine_unit: directed rows, then random command streams
// checked beat by beat against a behavioral list model held in the testbench
// depends on plist_pkg and the engine rtl
`timescale 1ns / 100ps

module tb;
    import plist_pkg::*;

    localparam int LIST_CAP       = 64;
    localparam int RAND_ITEMS     = 1125;
    localparam int PHASE_ITEMS    = 115;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 3000;

    // one result beat, split into its fields
    typedef struct packed {
        logic [VAL_W-1:0]   data;
        logic [FOUND_W-1:0] found;
        status_t            status;
        logic [LEN_W-1:0]   length;
        logic               empty;
    } list_result_t;

    // one directed stimulus row; want is used only when typed is set
    typedef struct {
        cmd_t             cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        bit               typed;
        list_result_t     want;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // list model state
    logic [VAL_W-1:0] list_vals [LIST_CAP];
    int               list_len = 0;

    list_result_t pending_results [$];
    dir_row_t     dir_rows [$];
    int           error_count = 0;
    int           stall_cycles = 0;
    bit           typed_on;
    list_result_t typed_want;
    bit           quiet;
    bit           hold_off_req;

    positional_list_engine_unit #(
        .CAPACITY (LIST_CAP)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    always #6 aclk = ~aclk;

    // apply one command to the list model and return its result
    function automatic list_result_t list_apply(cmd_t cmd, logic [POS_W-1:0] pos,
                                                logic [VAL_W-1:0] val);
        list_result_t r;
        int           p;
        int           i;
        r.data   = '0;
        r.found  = NOT_FOUND;
        r.status = ST_OK;
        p        = int'(pos);
        case (cmd)
            CMD_INSERT: begin
                if (p > list_len) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = list_len; i > p; i--)
                        list_vals[i] = list_vals[i-1];
                    list_vals[p] = val;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (p >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.data = list_vals[p];
                    for (i = p; i + 1 < list_len; i++)
                        list_vals[i] = list_vals[i+1];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (p >= list_len)
                    r.status = ST_BADPOS;
                else
                    r.data = list_vals[p];
            end
            default: begin
                // first match wins
                for (i = 0; i < list_len; i++) begin
                    if (list_vals[i] == val) begin
                        r.found = 7'(i);
                        break;
                    end
                end
            end
        endcase
        r.length = 7'(list_len);
        r.empty  = (list_len == 0);
        return r;
    endfunction

    function automatic list_result_t mk_result(logic [VAL_W-1:0] data,
                                               logic [FOUND_W-1:0] found,
                                               status_t status, int len, bit empty);
        list_result_t r;
        r.data   = data;
        r.found  = found;
        r.status = status;
        r.length = 7'(len);
        r.empty  = empty;
        return r;
    endfunction

    task automatic add_row(cmd_t cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                           bit typed, list_result_t want);
        dir_row_t row;
        row.cmd   = cmd;
        row.pos   = pos;
        row.val   = val;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endtask

    // offer one command beat at a falling edge, return at the falling edge after acceptance
    task automatic send_cmd(cmd_t cmd, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val,
                            bit typed, list_result_t want);
        logic [S_TDATA_W-1:0] beat;
        int                   gap;
        int                   r;
        gap = 0;
        if (!quiet) begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        beat = '0;
        beat[S_CMD_LSB +: CMD_W] = cmd;
        beat[S_POS_LSB +: POS_W] = pos;
        beat[S_VAL_LSB +: VAL_W] = val;
        s_tdata    <= beat;
        s_tvalid   <= 1'b1;
        typed_on   = typed;
        typed_want = want;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        @(negedge aclk);
    endtask

    // result checking and model update, both on accepted beats
    always @(posedge aclk) begin : result_check
        list_result_t want;
        list_result_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.data   = m_tdata[M_DATA_LSB +: VAL_W];
                got.found  = m_tdata[M_FOUND_LSB +: FOUND_W];
                got.status = status_t'(m_tdata[M_STATUS_LSB +: STATUS_W]);
                got.length = m_tdata[M_LEN_LSB +: LEN_W];
                got.empty  = m_tdata[M_EMPTY_LSB];
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("data_out", want.data, got.data);
                    check_field("found_position", 32'(want.found), 32'(got.found));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("length", 32'(want.length), 32'(got.length));
                    check_field("is_empty", 32'(want.empty), 32'(got.empty));
                end
            end
            if (s_tvalid && s_tready) begin
                want = list_apply(cmd_t'(s_tdata[S_CMD_LSB +: CMD_W]),
                                  s_tdata[S_POS_LSB +: POS_W],
                                  s_tdata[S_VAL_LSB +: VAL_W]);
                if (typed_on)
                    want = typed_want;
                pending_results.push_back(want);
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // result side ready, with random stalls and one long hold-off on request
    initial begin : result_ready
        int hold_cnt;
        int r;
        bit hold_done;
        hold_cnt  = 0;
        hold_done = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_cnt  = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (quiet) begin
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    hold_cnt = $urandom_range(10, 40);
                    m_tready <= 1'b0;
                end else if (r < 25) begin
                    hold_cnt = $urandom_range(0, 2);
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        int               n;
        int               r;
        int               phase;
        cmd_t             cmd;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        list_result_t     none;
        dir_row_t         row;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        typed_on     = 1'b0;
        typed_want   = '0;
        quiet        = 1'b0;
        hold_off_req = 1'b0;
        none         = '0;

        // directed rows: empty list errors, extremes, duplicates, every command
        add_row(CMD_READ,   7'd0,   32'h0, 1, mk_result(0, NOT_FOUND, ST_BADPOS, 0, 1));
        add_row(CMD_DELETE, 7'd0,   32'h0, 1, mk_result(0, NOT_FOUND, ST_BADPOS, 0, 1));
        add_row(CMD_FIND,   7'd0,   32'h0, 1, mk_result(0, NOT_FOUND, ST_OK, 0, 1));
        add_row(CMD_INSERT, 7'd1,   32'h5, 1, mk_result(0, NOT_FOUND, ST_BADPOS, 0, 1));
        add_row(CMD_INSERT, 7'd127, 32'h0, 1, mk_result(0, NOT_FOUND, ST_BADPOS, 0, 1));
        add_row(CMD_INSERT, 7'd0, 32'h8000_0000, 1, mk_result(0, NOT_FOUND, ST_OK, 1, 0));
        add_row(CMD_INSERT, 7'd1, 32'h7fff_ffff, 1, mk_result(0, NOT_FOUND, ST_OK, 2, 0));
        add_row(CMD_INSERT, 7'd0, 32'hffff_ffff, 1, mk_result(0, NOT_FOUND, ST_OK, 3, 0));
        add_row(CMD_INSERT, 7'd1,   32'h0, 0, none);
        add_row(CMD_READ,   7'd0,   32'h0, 0, none);
        add_row(CMD_READ,   7'd3,   32'h0, 0, none);
        add_row(CMD_READ,   7'd4,   32'h0, 1, mk_result(0, NOT_FOUND, ST_BADPOS, 4, 0));
        add_row(CMD_READ,   7'd127, 32'h0, 1, mk_result(0, NOT_FOUND, ST_BADPOS, 4, 0));
        add_row(CMD_FIND,   7'd0, 32'h7fff_ffff, 0, none);
        add_row(CMD_FIND,   7'd0,   32'h0, 0, none);
        add_row(CMD_FIND,   7'd127, 32'h1234_5678, 0, none);
        add_row(CMD_INSERT, 7'd4,   32'h0, 0, none);
        add_row(CMD_FIND,   7'd0,   32'h0, 0, none);
        add_row(CMD_DELETE, 7'd5,   32'h0, 1, mk_result(0, NOT_FOUND, ST_BADPOS, 5, 0));
        add_row(CMD_DELETE, 7'd127, 32'h0, 1, mk_result(0, NOT_FOUND, ST_BADPOS, 5, 0));
        add_row(CMD_DELETE, 7'd0,   32'h0, 0, none);
        add_row(CMD_DELETE, 7'd3,   32'h0, 0, none);
        add_row(CMD_DELETE, 7'd1,   32'h0, 0, none);
        add_row(CMD_DELETE, 7'd0,   32'h0, 0, none);
        add_row(CMD_DELETE, 7'd0, 32'h0, 1, mk_result(32'h7fff_ffff, NOT_FOUND, ST_OK, 0, 1));

        // reset
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            send_cmd(row.cmd, row.pos, row.val, row.typed, row.want);
        end

        // random part: grow, mix and shrink phases so the list fills and drains
        for (n = 0; n < RAND_ITEMS; n++) begin
            phase = (n / PHASE_ITEMS) % 4;
            quiet = ((n / PHASE_ITEMS) == 5);
            if (n == 500)
                hold_off_req = 1'b1;

            r = $urandom_range(0, 99);
            if (phase == 0)
                cmd = (r < 75) ? CMD_INSERT : (r < 85) ? CMD_DELETE :
                      (r < 92) ? CMD_READ : CMD_FIND;
            else if (phase == 2)
                cmd = (r < 15) ? CMD_INSERT : (r < 75) ? CMD_DELETE :
                      (r < 87) ? CMD_READ : CMD_FIND;
            else
                cmd = (r < 40) ? CMD_INSERT : (r < 65) ? CMD_DELETE :
                      (r < 82) ? CMD_READ : CMD_FIND;

            // position: mostly in range, sometimes at the boundary or anywhere
            r = $urandom_range(0, 99);
            if (r < 8)
                pos = 7'($urandom_range(0, 127));
            else if (r < 14)
                pos = 7'(list_len);
            else if (cmd == CMD_INSERT)
                pos = 7'($urandom_range(0, list_len));
            else if (list_len == 0)
                pos = '0;
            else
                pos = 7'($urandom_range(0, list_len - 1));

            // value: extremes, a narrow range for duplicates, or fully random
            r = $urandom_range(0, 99);
            if (r < 3)
                val = 32'h8000_0000;
            else if (r < 6)
                val = 32'h7fff_ffff;
            else if (r < 8)
                val = 32'hffff_ffff;
            else if (r < 10)
                val = 32'h0;
            else if (r < 35)
                val = 32'($urandom_range(0, 7));
            else
                val = $urandom;
            if (cmd == CMD_FIND && list_len > 0 && $urandom_range(0, 99) < 60)
                val = list_vals[$urandom_range(0, list_len - 1)];

            send_cmd(cmd, pos, val, 0, none);
        end
        s_tvalid <= 1'b0;
        quiet = 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/plist_pkg.sv
sv/plist_ram.sv
sv/positional_list_engine_unit.sv
sim/tb.sv
